// File: rtl/elpt_pkg.sv
package elpt_pkg;

  // Fixed widths of the stream fields.
  localparam int KIND_W  = 1;
  localparam int SLOT_W  = 5;
  localparam int FIELD_W = 31;
  localparam int CIDX_W  = 6;
  localparam int TOTAL_W = 37;

  // Item kinds carried on the input tuser.
  localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // Controls from the sequencer to the walk datapath and the top level.
  typedef struct packed {
    logic idle;
    logic clear;
    logic step;
    logic load;
  } ctl_t;

endpackage

// File: rtl/elpt_ram.sv
module elpt_ram import elpt_pkg::*; #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/elpt_walk.sv
module elpt_walk import elpt_pkg::*; #(
  parameter int POS_BITS = 31,
  parameter int ACC_W    = 37,
  parameter int CW       = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_t                ctl,
  input  logic [POS_BITS-1:0] pos,
  input  logic [CW-1:0]       idx,
  input  logic [POS_BITS-1:0] ent_first,
  input  logic [POS_BITS:0]   ent_len,
  output logic                found,
  output logic [POS_BITS:0]   src,
  output logic [CW-1:0]       hit_idx,
  output logic [ACC_W-1:0]    total
);

  logic [ACC_W-1:0]    start_r, start_nxt;
  logic                hit_r, hit_nxt;
  logic [CW-1:0]       hidx_r, hidx_nxt;
  logic [POS_BITS-1:0] hfirst_r, hfirst_nxt;
  logic [POS_BITS-1:0] hoff_r, hoff_nxt;
  logic [ACC_W:0]      off;
  logic                match;

  // Offset of the position from the start of the current clip; the top bit is the borrow.
  assign off   = {1'b0, {(ACC_W - POS_BITS){1'b0}}, pos} - {1'b0, start_r};
  assign match = !off[ACC_W] &&
                 (off[ACC_W-1:0] < {{(ACC_W - POS_BITS - 1){1'b0}}, ent_len});

  // Advance the running start and capture the first matching clip.
  always_comb begin
    start_nxt  = start_r;
    hit_nxt    = hit_r;
    hidx_nxt   = hidx_r;
    hfirst_nxt = hfirst_r;
    hoff_nxt   = hoff_r;
    if (ctl.clear) begin
      start_nxt = '0;
      hit_nxt   = 1'b0;
    end else if (ctl.step) begin
      start_nxt = start_r + {{(ACC_W - POS_BITS - 1){1'b0}}, ent_len};
      if (!hit_r && match) begin
        hit_nxt    = 1'b1;
        hidx_nxt   = idx;
        hfirst_nxt = ent_first;
        hoff_nxt   = off[POS_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    hidx_r   <= hidx_nxt;
    hfirst_r <= hfirst_nxt;
    hoff_r   <= hoff_nxt;
  end

  // The source position is formed combinationally from the captured clip start and offset.
  assign src     = {1'b0, hfirst_r} + {1'b0, hoff_r};
  assign found   = hit_r;
  assign hit_idx = hidx_r;
  assign total   = start_r;

endmodule

// File: rtl/elpt_ctrl.sv
module elpt_ctrl import elpt_pkg::*; #(
  parameter int NUM_CLIPS = 32,
  parameter int CW        = 6,
  parameter int AW        = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          query_acc,
  input  logic          ent_end,
  input  logic          out_free,
  output ctl_t          ctl,
  output logic [CW-1:0] idx,
  output logic [CW-1:0] cnt,
  output logic [AW-1:0] rd_addr
);

  localparam logic [CW-1:0] LAST = CW'(NUM_CLIPS - 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_inc;
  logic          stop;

  assign idx_inc = idx_r + CW'(1);
  assign stop    = ent_end || (idx_r == LAST);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (stop) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs to the datapath and the table read port.
  // The walk registers are held clear while idle, so a query starts from zero.
  always_comb begin
    ctl     = '0;
    rd_addr = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.idle  = 1'b1;
        ctl.clear = 1'b1;
      end
      ST_WALK: begin
        ctl.step = !ent_end;
        if (idx_r != LAST) begin
          rd_addr = idx_inc[AW-1:0];
        end
      end
      ST_DONE: begin
        ctl.load = out_free;
      end
      default: ctl = '0;
    endcase
  end

  // Entry counter and the count of clips walked.
  always_comb begin
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    if (query_acc && state_r == ST_IDLE) begin
      idx_nxt = '0;
    end else if (state_r == ST_WALK) begin
      if (stop) begin
        cnt_nxt = ent_end ? idx_r : idx_inc;
      end else begin
        idx_nxt = idx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
  end

  assign idx = idx_r;
  assign cnt = cnt_r;

endmodule

// File: rtl/edit_list_position_translator_unit.sv
// A write item leaves the block idle, so it stays ready for the next item.
// A query walks the clip RAM from entry 0 until a zero-last entry, an unwritten entry or
// the last table entry; one entry is examined per cycle by the shared offset/accumulate
// unit reading the clip RAM.
// No new item is accepted until the result of a query is loaded into the output register.
// Reset clears the per-entry valid bits at once, so the table reads as an empty list.
module edit_list_position_translator_unit import elpt_pkg::*; #(
  parameter int NUM_CLIPS = 32,
  parameter int POS_BITS  = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_index[4:0], clip_first[35:5], clip_last[66:36], edit_position[97:67]
  input  logic [103:0] in_tdata,
  // kind[0]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // source_position[30:0], clip_index[36:31], total_length[73:37]
  output logic [79:0]  out_tdata,
  // found[0]
  output logic [0:0]   out_tuser
);

  localparam int AW     = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1;
  localparam int CW     = $clog2(NUM_CLIPS + 1);
  localparam int ACC_W  = POS_BITS + $clog2(NUM_CLIPS) + 1;
  localparam int WORD_W = 2 * POS_BITS + 2;

  // Input field unpacking.
  logic [SLOT_W-1:0]  in_slot;
  logic [FIELD_W-1:0] in_first, in_last, in_pos;
  logic [KIND_W-1:0]  in_kind;

  assign in_slot  = in_tdata[4:0];
  assign in_first = in_tdata[35:5];
  assign in_last  = in_tdata[66:36];
  assign in_pos   = in_tdata[97:67];
  assign in_kind  = in_tuser;

  // Fields resized to the internal position width.
  logic [POS_BITS+FIELD_W-1:0] first_pad, last_pad, pos_pad;
  logic [POS_BITS-1:0]         w_first, w_last, q_pos;

  assign first_pad = {{POS_BITS{1'b0}}, in_first};
  assign last_pad  = {{POS_BITS{1'b0}}, in_last};
  assign pos_pad   = {{POS_BITS{1'b0}}, in_pos};
  assign w_first   = first_pad[POS_BITS-1:0];
  assign w_last    = last_pad[POS_BITS-1:0];
  assign q_pos     = pos_pad[POS_BITS-1:0];

  ctl_t ctl;
  logic in_acc, wr_en, query_acc, slot_ok;

  assign in_tready = ctl.idle;
  assign in_acc    = in_tvalid && in_tready;
  assign slot_ok   = ({4'b0, in_slot} < 9'(NUM_CLIPS));
  assign wr_en     = in_acc && (in_kind == KIND_WRITE) && slot_ok;
  assign query_acc = in_acc && (in_kind == KIND_QUERY);

  // Clip length is worked out when the entry is written; a reversed clip has none.
  logic [POS_BITS:0]   w_diff, w_len;
  logic                w_end;
  logic [WORD_W-1:0]   w_word;
  logic [AW+SLOT_W-1:0] slot_pad;
  logic [AW-1:0]       w_addr;

  assign w_diff   = {1'b0, w_last} - {1'b0, w_first};
  assign w_len    = w_diff[POS_BITS] ? '0 : (w_diff + (POS_BITS+1)'(1));
  assign w_end    = (w_last == '0);
  assign w_word   = {w_end, w_len, w_first};
  assign slot_pad = {{AW{1'b0}}, in_slot};
  assign w_addr   = slot_pad[AW-1:0];

  // Valid bits: an entry never written reads as an end-of-list marker.
  logic [NUM_CLIPS-1:0] valid_r;
  logic                 ent_vld_r;
  logic [AW-1:0]        rd_addr;
  logic [WORD_W-1:0]    rd_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[w_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ent_vld_r <= valid_r[rd_addr];
  end

  elpt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_CLIPS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (w_addr),
    .wdata (w_word),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  logic                ent_end;
  logic [POS_BITS-1:0] ent_first;
  logic [POS_BITS:0]   ent_len;

  assign ent_end   = !ent_vld_r || rd_word[WORD_W-1];
  assign ent_first = rd_word[POS_BITS-1:0];
  assign ent_len   = rd_word[WORD_W-2:POS_BITS];

  // Query position, held for the walk.
  logic [POS_BITS-1:0] pos_r;

  always_ff @(posedge clk) begin
    if (query_acc) begin
      pos_r <= q_pos;
    end
  end

  logic          out_free;
  logic [CW-1:0] idx, cnt;

  assign out_free = !out_tvalid || out_tready;

  elpt_ctrl #(
    .NUM_CLIPS (NUM_CLIPS),
    .CW        (CW),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .query_acc (query_acc),
    .ent_end   (ent_end),
    .out_free  (out_free),
    .ctl       (ctl),
    .idx       (idx),
    .cnt       (cnt),
    .rd_addr   (rd_addr)
  );

  logic                found;
  logic [POS_BITS:0]   src;
  logic [CW-1:0]       hit_idx;
  logic [ACC_W-1:0]    total;

  elpt_walk #(
    .POS_BITS (POS_BITS),
    .ACC_W    (ACC_W),
    .CW       (CW)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .pos       (pos_r),
    .idx       (idx),
    .ent_first (ent_first),
    .ent_len   (ent_len),
    .found     (found),
    .src       (src),
    .hit_idx   (hit_idx),
    .total     (total)
  );

  // Result fields fitted to the output widths.
  logic [POS_BITS+FIELD_W:0] src_pad;
  logic [CW+CIDX_W-1:0]      cidx_pad;
  logic [ACC_W+TOTAL_W-1:0]  total_pad;

  assign src_pad   = {{FIELD_W{1'b0}}, src};
  assign cidx_pad  = {{CIDX_W{1'b0}}, (found ? hit_idx : cnt)};
  assign total_pad = {{TOTAL_W{1'b0}}, total};

  // Output register; it holds a result until the transfer completes.
  logic               out_tvalid_r;
  logic               out_found_r;
  logic [FIELD_W-1:0] out_src_r;
  logic [CIDX_W-1:0]  out_cidx_r;
  logic [TOTAL_W-1:0] out_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_found_r <= found;
      out_src_r   <= found ? src_pad[FIELD_W-1:0] : '0;
      out_cidx_r  <= cidx_pad[CIDX_W-1:0];
      out_total_r <= total_pad[TOTAL_W-1:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {6'b0, out_total_r, out_cidx_r, out_src_r};

  // A query holds off further input for at least the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == KIND_QUERY) |=> !in_tready)
    else $error("input accepted right after a query transfer");

  // A matching clip always lies inside the table.
  a_hit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> ({3'b0, out_tdata[36:31]} < 9'(NUM_CLIPS)))
    else $error("matching clip index beyond the table");

  // A miss carries a zero source position.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[30:0] == '0))
    else $error("nonzero source position on a miss");

  // A result is loaded only when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> (!out_tvalid || out_tready))
    else $error("result loaded over one still waiting");

endmodule
